// ===== rtl/dbc_pkg.sv =====
// Shared constants, record kinds and the record-set type of the delimiter balance checker.
package dbc_pkg;

    localparam int DEPTH_BITS = 16;
    localparam int LINE_BITS  = 24;
    localparam int COL_BITS   = 16;
    localparam int REC_SLOTS  = 4;

    localparam logic [7:0] CH_OPEN_BRACE    = 8'h7B;
    localparam logic [7:0] CH_CLOSE_BRACE   = 8'h7D;
    localparam logic [7:0] CH_OPEN_PAREN    = 8'h28;
    localparam logic [7:0] CH_CLOSE_PAREN   = 8'h29;
    localparam logic [7:0] CH_OPEN_BRACKET  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_BRACKET = 8'h5D;
    localparam logic [7:0] CH_NEWLINE       = 8'h0A;

    localparam logic OP_CHAR   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef enum logic [2:0] {
        KIND_CLOSE_BRACE   = 3'd0,
        KIND_CLOSE_PAREN   = 3'd1,
        KIND_CLOSE_BRACKET = 3'd2,
        KIND_OPEN_BRACE    = 3'd3,
        KIND_OPEN_PAREN    = 3'd4,
        KIND_OPEN_BRACKET  = 3'd5,
        KIND_END           = 3'd6
    } t_err_kind;

    // mask[0..2]: unclosed brace/paren/bracket; mask[3]: final record of kind fin_kind
    typedef struct packed {
        logic [REC_SLOTS-1:0] mask;
        t_err_kind            fin_kind;
        logic [LINE_BITS-1:0] line;
        logic [COL_BITS-1:0]  col;
    } t_rec_set;

endpackage

// ===== rtl/dbc_track.sv =====
// Depth, line and column counters and the record set each word gives rise to.
module dbc_track (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_opcode,
    input  logic [7:0]          i_text_char,
    output dbc_pkg::t_rec_set   o_rec
);

    localparam logic [dbc_pkg::DEPTH_BITS-1:0] DEPTH_MAX = '1;
    localparam logic [dbc_pkg::LINE_BITS-1:0]  LINE_MAX  = '1;
    localparam logic [dbc_pkg::COL_BITS-1:0]   COL_MAX   = '1;
    localparam logic [dbc_pkg::LINE_BITS-1:0]  LINE_ONE  = dbc_pkg::LINE_BITS'(1);
    localparam logic [dbc_pkg::COL_BITS-1:0]   COL_ONE   = dbc_pkg::COL_BITS'(1);

    logic [dbc_pkg::DEPTH_BITS-1:0] r_brace, n_brace;
    logic [dbc_pkg::DEPTH_BITS-1:0] r_paren, n_paren;
    logic [dbc_pkg::DEPTH_BITS-1:0] r_bracket, n_bracket;
    logic [dbc_pkg::LINE_BITS-1:0]  r_line, n_line;
    logic [dbc_pkg::COL_BITS-1:0]   r_col, n_col;
    dbc_pkg::t_rec_set              rec;

    always_comb begin
        n_brace   = r_brace;
        n_paren   = r_paren;
        n_bracket = r_bracket;
        n_line    = r_line;
        n_col     = r_col;
        rec       = '0;
        rec.fin_kind = dbc_pkg::KIND_END;
        rec.line     = r_line;
        rec.col      = r_col;
        if (i_opcode == dbc_pkg::OP_FINISH) begin
            rec.mask  = {1'b1, r_bracket != '0, r_paren != '0, r_brace != '0};
            n_brace   = '0;
            n_paren   = '0;
            n_bracket = '0;
            n_line    = LINE_ONE;
            n_col     = COL_ONE;
        end else if (i_text_char == dbc_pkg::CH_NEWLINE) begin
            n_line = (r_line == LINE_MAX) ? r_line : r_line + LINE_ONE;
            n_col  = COL_ONE;
        end else begin
            n_col   = (r_col == COL_MAX) ? r_col : r_col + COL_ONE;
            rec.col = n_col;   // close errors report the advanced column
            case (i_text_char)
                dbc_pkg::CH_OPEN_BRACE: begin
                    if (r_brace != DEPTH_MAX) n_brace = r_brace + 1'b1;
                end
                dbc_pkg::CH_OPEN_PAREN: begin
                    if (r_paren != DEPTH_MAX) n_paren = r_paren + 1'b1;
                end
                dbc_pkg::CH_OPEN_BRACKET: begin
                    if (r_bracket != DEPTH_MAX) n_bracket = r_bracket + 1'b1;
                end
                dbc_pkg::CH_CLOSE_BRACE: begin
                    if (r_brace == '0) begin
                        rec.mask     = 4'b1000;
                        rec.fin_kind = dbc_pkg::KIND_CLOSE_BRACE;
                    end else begin
                        n_brace = r_brace - 1'b1;
                    end
                end
                dbc_pkg::CH_CLOSE_PAREN: begin
                    if (r_paren == '0) begin
                        rec.mask     = 4'b1000;
                        rec.fin_kind = dbc_pkg::KIND_CLOSE_PAREN;
                    end else begin
                        n_paren = r_paren - 1'b1;
                    end
                end
                dbc_pkg::CH_CLOSE_BRACKET: begin
                    if (r_bracket == '0) begin
                        rec.mask     = 4'b1000;
                        rec.fin_kind = dbc_pkg::KIND_CLOSE_BRACKET;
                    end else begin
                        n_bracket = r_bracket - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brace   <= '0;
            r_paren   <= '0;
            r_bracket <= '0;
            r_line    <= LINE_ONE;
            r_col     <= COL_ONE;
        end else if (i_accept) begin
            r_brace   <= n_brace;
            r_paren   <= n_paren;
            r_bracket <= n_bracket;
            r_line    <= n_line;
            r_col     <= n_col;
        end
    end

    assign o_rec = rec;

endmodule

// ===== rtl/dbc_emit.sv =====
// Result register: holds the pending record set and hands out the records of a word one at a time.
module dbc_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  dbc_pkg::t_rec_set   i_rec,
    input  logic                i_out_stall,
    output logic                o_busy,
    output logic                o_out_valid,
    output logic [2:0]          o_error_kind,
    output logic [23:0]         o_line_number,
    output logic [15:0]         o_column_number,
    output logic                o_last_record
);

    logic [dbc_pkg::REC_SLOTS-1:0] r_mask, n_mask;
    dbc_pkg::t_err_kind            r_fin_kind;
    logic [dbc_pkg::LINE_BITS-1:0] r_line;
    logic [dbc_pkg::COL_BITS-1:0]  r_col;
    logic                          take;
    dbc_pkg::t_err_kind            cur_kind;

    assign take = o_out_valid && !i_out_stall;

    always_comb begin
        if (i_load) begin
            n_mask = i_rec.mask;
        end else if (take) begin
            n_mask = r_mask & (r_mask - 1'b1);   // drop lowest pending record
        end else begin
            n_mask = r_mask;
        end
    end

    always_comb begin
        if (r_mask[0]) begin
            cur_kind = dbc_pkg::KIND_OPEN_BRACE;
        end else if (r_mask[1]) begin
            cur_kind = dbc_pkg::KIND_OPEN_PAREN;
        end else if (r_mask[2]) begin
            cur_kind = dbc_pkg::KIND_OPEN_BRACKET;
        end else begin
            cur_kind = r_fin_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_fin_kind <= i_rec.fin_kind;
            r_line     <= i_rec.line;
            r_col      <= i_rec.col;
        end
    end

    // new word may enter once nothing is pending or the final record leaves now
    assign o_busy = (r_mask != '0) && !((r_mask == 4'b1000) && !i_out_stall);

    assign o_out_valid     = (r_mask != '0);
    assign o_error_kind    = cur_kind;
    assign o_line_number   = r_line;
    assign o_column_number = r_col;
    assign o_last_record   = (r_mask == 4'b1000);

    a_unclosed_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (cur_kind == dbc_pkg::KIND_OPEN_BRACE
            || cur_kind == dbc_pkg::KIND_OPEN_PAREN
            || cur_kind == dbc_pkg::KIND_OPEN_BRACKET)) |-> !o_last_record)
        else $error("unclosed record flagged as last");

    a_records_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !o_last_record) |=> o_out_valid)
        else $error("records of one word interrupted");

    a_no_load_midway: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_record) |-> !i_load)
        else $error("new word taken while records still pending");

    a_drained_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && o_last_record && !i_load) |=> !o_out_valid)
        else $error("record appeared without a new word");

endmodule

// ===== rtl/delimiter_balance_checker.sv =====
// Top level of the delimiter balance checker: counters feeding a record output register.
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+--------------------------------------------------
//  in      | i_in_valid  | o_in_stall   | i_opcode, i_text_char
//  out     | o_out_valid | i_out_stall  | o_error_kind, o_line_number, o_column_number,
//          |             |              | o_last_record
//
// One word is taken per cycle unless stalled; counters update at the accepting edge.
// Records leave the output register in the cycle after acceptance, one per cycle
// unless i_out_stall is high; a finish word gives one to four and holds input meanwhile.
// Input stall is raised while earlier records are pending, but not as the last one leaves.
// Synchronous active-low reset clears depths to 0, line and column to 1.
module delimiter_balance_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_text_char,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_error_kind,
    output logic [23:0] o_line_number,
    output logic [15:0] o_column_number,
    output logic        o_last_record
);

    dbc_pkg::t_rec_set rec;
    logic              accept;
    logic              busy;

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    dbc_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_opcode    (i_opcode),
        .i_text_char (i_text_char),
        .o_rec       (rec)
    );

    dbc_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (accept),
        .i_rec           (rec),
        .i_out_stall     (i_out_stall),
        .o_busy          (busy),
        .o_out_valid     (o_out_valid),
        .o_error_kind    (o_error_kind),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number),
        .o_last_record   (o_last_record)
    );

endmodule
